### rtl/ssi_pkg.sv
// Shared types, constants and state encoding for the signed key sorter.
package ssi_pkg;

    localparam int SSI_DEPTH = 64;
    localparam int KEY_W     = 64;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    last_item;
    } t_in_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] sorted_key;
        logic                    last_result;
        logic                    overflowed;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PRIME,
        ST_MERGE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic prime;
        logic merge;
        logic emit;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic sorted;
        logic pass_end;
        logic emit_done;
    } t_status;

endpackage

### rtl/sort_signed_integers_core.sv
// Batch sorter for signed 64-bit keys: top level joining controller and datapath.
//
// Input channel: one key per transaction, last_item closes the batch. Keys beyond
// DEPTH in one batch are dropped and every result of that batch carries overflowed.
// Output channel: the batch in ascending signed order, one key per transaction,
// last_result set on the final one.
// For a batch of n stored keys: loading accepts one key per cycle. The sort is
// a bottom-up merge between two key banks in ceil(log2 n) passes, each preceded
// by a setup step; a pass writes each key once, through the single write port of a bank.
// Emission then follows a setup step and delivers one key per cycle while the
// receiver does not stall. Inputs are stalled after the closing key until the batch
// has been cleared, after the last result has entered the output register.
// The output register holds a result while i_out_stall is high; emission pauses.
// Reset empties the batch and the output register. The banks are not cleared:
// only entries written in the current batch are ever read.
module sort_signed_integers_core #(
    parameter int DEPTH = ssi_pkg::SSI_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ssi_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ssi_pkg::t_out_item o_out
);
    import ssi_pkg::*;

    t_cmd    cmd;
    t_status status;

    ssi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_item (i_in.last_item),
        .o_in_stall  (o_in_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ssi_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

### rtl/ssi_ctrl.sv
// Sequencer for the sorter: load, merge passes and result emission.
module ssi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_last_item,
    output logic             o_in_stall,
    input  ssi_pkg::t_status i_status,
    output ssi_pkg::t_cmd    o_cmd
);
    import ssi_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_item) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_PRIME;
                    end
                end
            end
            ST_PRIME: begin
                // Sets up the run pointers and fetches the first heads.
                o_cmd.prime = 1'b1;
                n_state     = i_status.sorted ? ST_EMIT : ST_MERGE;
            end
            ST_MERGE: begin
                o_cmd.merge = 1'b1;
                if (i_status.pass_end) begin
                    n_state = ST_PRIME;
                end
            end
            ST_EMIT: begin
                if (i_status.emit_done) begin
                    o_cmd.clear = 1'b1;
                    n_state     = ST_LOAD;
                end else begin
                    o_cmd.emit = 1'b1;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

### rtl/ssi_dpath.sv
// Key stores, bottom-up merge datapath and output register of the sorter.
module ssi_dpath #(
    parameter int DEPTH = ssi_pkg::SSI_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssi_pkg::t_cmd      i_cmd,
    output ssi_pkg::t_status   o_status,
    input  ssi_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ssi_pkg::t_out_item o_out
);
    import ssi_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 2;

    logic [KEY_W-1:0] r_bank0 [DEPTH];
    logic [KEY_W-1:0] r_bank1 [DEPTH];
    logic [KEY_W-1:0] r_ra0, r_rb0, r_ra1, r_rb1;

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [SW-1:0] r_w;
    logic          r_src;
    logic [CW-1:0] r_i, r_mid, r_j, r_hi, r_k;
    logic [CW-1:0] n_i, n_mid, n_j, n_hi, n_k;

    logic          r_out_valid;
    t_out_item     r_out;

    logic [KEY_W-1:0] ra, rb, wr_data;
    logic             a_ok, b_ok, b_less, take_a;
    logic [SW-1:0]    k_inc, hi_w, hi_2w;
    logic             seg_end, pass_end;
    logic             store_en, emit_load;

    function automatic logic [CW-1:0] clip(input logic [SW-1:0] v, input logic [CW-1:0] n);
        clip = (v < SW'(n)) ? v[CW-1:0] : n;
    endfunction

    assign ra      = r_src ? r_ra1 : r_ra0;
    assign rb      = r_src ? r_rb1 : r_rb0;
    assign a_ok    = r_i < r_mid;
    assign b_ok    = r_j < r_hi;
    assign b_less  = $signed(rb) < $signed(ra);
    assign take_a  = a_ok && (!b_ok || !b_less);
    assign wr_data = take_a ? ra : rb;

    assign k_inc    = SW'(r_k) + SW'(1);
    assign seg_end  = k_inc == SW'(r_hi);
    assign pass_end = k_inc == SW'(r_count);
    assign hi_w     = SW'(r_hi) + r_w;
    assign hi_2w    = SW'(r_hi) + (r_w << 1);

    assign store_en  = i_cmd.load && (r_count < CW'(DEPTH));
    assign emit_load = i_cmd.emit && (r_i < r_count) && (!r_out_valid || !i_out_stall);

    assign o_status.sorted    = r_w >= SW'(r_count);
    assign o_status.pass_end  = pass_end;
    assign o_status.emit_done = r_i == r_count;

    always_comb begin
        n_i   = r_i;
        n_mid = r_mid;
        n_j   = r_j;
        n_hi  = r_hi;
        n_k   = r_k;
        if (i_cmd.prime) begin
            n_i   = '0;
            n_k   = '0;
            n_mid = clip(r_w, r_count);
            n_j   = clip(r_w, r_count);
            n_hi  = clip(r_w << 1, r_count);
        end else if (i_cmd.merge) begin
            if (seg_end) begin
                // Next pair of runs starts where this one ended.
                n_i   = r_hi;
                n_mid = clip(hi_w, r_count);
                n_j   = clip(hi_w, r_count);
                n_hi  = clip(hi_2w, r_count);
            end else if (take_a) begin
                n_i = r_i + CW'(1);
            end else begin
                n_j = r_j + CW'(1);
            end
            n_k = pass_end ? '0 : r_k + CW'(1);
        end else if (emit_load) begin
            n_i = r_i + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_w         <= SW'(1);
            r_src       <= 1'b0;
            r_i         <= '0;
            r_mid       <= '0;
            r_j         <= '0;
            r_hi        <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_i   <= n_i;
            r_mid <= n_mid;
            r_j   <= n_j;
            r_hi  <= n_hi;
            r_k   <= n_k;
            if (i_cmd.load) begin
                if (store_en) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.start) begin
                r_w   <= SW'(1);
                r_src <= 1'b0;
            end else if (i_cmd.merge && pass_end) begin
                r_w   <= r_w << 1;
                r_src <= ~r_src;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Bank 0 takes the incoming keys and the output of passes that read bank 1.
    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_bank0[r_count[AW-1:0]] <= i_in.key;
        end else if (i_cmd.merge && r_src) begin
            r_bank0[r_k[AW-1:0]] <= wr_data;
        end
        r_ra0 <= r_bank0[n_i[AW-1:0]];
        r_rb0 <= r_bank0[n_j[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.merge && !r_src) begin
            r_bank1[r_k[AW-1:0]] <= wr_data;
        end
        r_ra1 <= r_bank1[n_i[AW-1:0]];
        r_rb1 <= r_bank1[n_j[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out.sorted_key  <= ra;
            r_out.last_result <= (SW'(r_i) + SW'(1)) == SW'(r_count);
            r_out.overflowed  <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_merge_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge |-> (a_ok || b_ok))
        else $error("merge step with both runs exhausted");

    a_run_width_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_w))
        else $error("run width is not a power of two");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("stored key count beyond depth");

endmodule

### verif/ssi_checker.sv
// Checker for the signed key sorter: predicts each batch's sorted output and compares it.
`timescale 1ns / 100ps

module ssi_checker #(
    parameter int DEPTH = ssi_pkg::SSI_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  ssi_pkg::t_in_item  i_in,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  ssi_pkg::t_out_item i_out,
    output int                 o_fail_count,
    output int                 o_pending
);

    import ssi_pkg::*;

    logic signed [KEY_W-1:0] batch_keys [DEPTH];
    int                      batch_count;
    logic                    batch_dropped;
    t_out_item               sorted_due [$];
    int                      mismatches;

    // Stores one key; a closing key sorts the batch and queues one result per stored key.
    task automatic take_key(input t_in_item item);
        int                      i;
        int                      j;
        logic signed [KEY_W-1:0] v;
        t_out_item               res;
        if (batch_count < DEPTH) begin
            batch_keys[batch_count] = item.key;
            batch_count++;
        end else begin
            batch_dropped = 1'b1;
        end
        if (item.last_item) begin
            for (i = 1; i < batch_count; i++) begin
                v = batch_keys[i];
                j = i;
                while (j > 0 && v < batch_keys[j-1]) begin
                    batch_keys[j] = batch_keys[j-1];
                    j--;
                end
                batch_keys[j] = v;
            end
            for (i = 0; i < batch_count; i++) begin
                res.sorted_key  = batch_keys[i];
                res.last_result = (i == batch_count - 1);
                res.overflowed  = batch_dropped;
                sorted_due.push_back(res);
            end
            batch_count   = 0;
            batch_dropped = 1'b0;
        end
    endtask

    task automatic check_sorted(input t_out_item got);
        t_out_item want;
        if (sorted_due.size() == 0) begin
            $error("unexpected transaction: sorted_key %0d last_result %0b overflowed %0b",
                   got.sorted_key, got.last_result, got.overflowed);
            mismatches++;
        end else begin
            want = sorted_due.pop_front();
            if (got.sorted_key !== want.sorted_key) begin
                $error("sorted_key: expected %0d, got %0d", want.sorted_key, got.sorted_key);
                mismatches++;
            end
            if (got.last_result !== want.last_result) begin
                $error("last_result: expected %0b, got %0b", want.last_result, got.last_result);
                mismatches++;
            end
            if (got.overflowed !== want.overflowed) begin
                $error("overflowed: expected %0b, got %0b", want.overflowed, got.overflowed);
                mismatches++;
            end
        end
    endtask

    initial begin
        mismatches    = 0;
        batch_count   = 0;
        batch_dropped = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            batch_count   = 0;
            batch_dropped = 1'b0;
            sorted_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_sorted(i_out);
            end
            if (i_in_valid && !i_in_stall) begin
                take_key(i_in);
            end
        end
        o_pending    <= sorted_due.size();
        o_fail_count <= mismatches;
    end

endmodule

### verif/tb_sort_signed_integers_core.sv
// Testbench top for the signed key sorter: clock, reset, key batches, output stalls and verdict.
`timescale 1ns / 100ps

module tb_sort_signed_integers_core;

    import ssi_pkg::*;

    localparam int DEPTH       = SSI_DEPTH;
    localparam int ITEMS       = 330;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT       = 300000;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 64'sh8000_0000_0000_0000;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;
    int        fail_count;
    int        pending;

    int        cycles      = 0;
    int        holds_asked = 0;
    int        holds_done  = 0;
    int        sender_calm = 0;
    int        keys_sent   = 0;

    always #6 i_clk = ~i_clk;

    sort_signed_integers_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_item)
    );

    ssi_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("sort_signed_integers_core: mismatch");
            $finish;
        end
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [KEY_W-1:0] draw_key();
        logic signed [KEY_W-1:0] k;
        int                      r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            k = {$urandom(), $urandom()};
        end else if (r < 75) begin
            // A narrow range around zero gives plenty of equal keys.
            k = KEY_W'($urandom_range(0, 20));
            k = k - 10;
        end else begin
            case ($urandom_range(0, 6))
                0:       k = KEY_MIN;
                1:       k = KEY_MAX;
                2:       k = KEY_MIN + 1;
                3:       k = KEY_MAX - 1;
                4:       k = -1;
                5:       k = 1;
                default: k = 0;
            endcase
        end
        return k;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic offer_key(input logic signed [KEY_W-1:0] k, input logic closing);
        int gap;
        gap = 0;
        if (sender_calm > 0) begin
            sender_calm--;
        end else if ($urandom_range(0, 99) < 4) begin
            sender_calm = $urandom_range(20, 60);
        end else if ($urandom_range(0, 99) < 40) begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_item.key       = k;
        in_item.last_item = closing;
        in_valid          = 1'b1;
        do @(posedge i_clk); while (in_stall);
        keys_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_batch(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            offer_key(draw_key(), i == n - 1);
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Receiver: random stalls, calm stretches, and long hold-offs on request.
    initial begin
        int stall_left;
        int calm_left;
        int hold_left;
        int r;
        stall_left = 0;
        calm_left  = 0;
        hold_left  = 0;
        out_stall  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_done < holds_asked) begin
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                if (hold_left == 0) begin
                    holds_done++;
                end
                out_stall = 1'b1;
            end else begin
                if (stall_left == 0 && calm_left == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 8) begin
                        calm_left = $urandom_range(30, 100);
                    end else if (r < 40) begin
                        stall_left = pick_gap();
                    end
                end
                if (stall_left > 0) begin
                    stall_left--;
                    out_stall = 1'b1;
                end else begin
                    if (calm_left > 0) begin
                        calm_left--;
                    end
                    out_stall = 1'b0;
                end
            end
        end
    end

    initial begin
        int batch;
        int n;
        int r;
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // A batch of one key.
        offer_key(KEY_MAX, 1'b1);
        // Both extremes and their neighbors, around zero.
        offer_key(KEY_MAX, 1'b0);
        offer_key(1, 1'b0);
        offer_key(0, 1'b0);
        offer_key(-1, 1'b0);
        offer_key(KEY_MIN, 1'b0);
        offer_key(KEY_MAX - 1, 1'b0);
        offer_key(KEY_MIN + 1, 1'b1);
        // Equal keys.
        offer_key(5, 1'b0);
        offer_key(5, 1'b0);
        offer_key(-5, 1'b0);
        offer_key(5, 1'b0);
        offer_key(-5, 1'b1);
        // Already ascending input.
        offer_key(-3, 1'b0);
        offer_key(-2, 1'b0);
        offer_key(2, 1'b0);
        offer_key(3, 1'b1);
        // Alternating and half-word bit patterns.
        offer_key(64'sh5555_5555_5555_5555, 1'b0);
        offer_key(64'shAAAA_AAAA_AAAA_AAAA, 1'b0);
        offer_key(64'sh0000_0000_FFFF_FFFF, 1'b0);
        offer_key(64'shFFFF_FFFF_0000_0000, 1'b0);
        offer_key(64'sh8000_0000_0000_0001, 1'b1);
        offer_key(KEY_MIN, 1'b1);
        drain();

        batch = 0;
        while (keys_sent < ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                n = $urandom_range(1, 8);
            end else if (r < 92) begin
                n = $urandom_range(9, 24);
            end else begin
                n = $urandom_range(25, 40);
            end
            case (batch)
                4:  n = DEPTH;
                // The closing key itself arrives with the store full and is dropped.
                11: n = DEPTH + 1;
                19: n = DEPTH + $urandom_range(2, 8);
                default: ;
            endcase
            // The receiver holds off while the sender keeps offering, so the input backs up.
            if (batch == 7 || batch == 28) begin
                holds_asked++;
            end
            send_batch(n);
            if (batch == 14 || $urandom_range(0, 99) < 5) begin
                drain();
            end
            batch++;
        end

        drain();
        repeat (60) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("sort_signed_integers_core: match");
        end else begin
            $display("sort_signed_integers_core: mismatch");
        end
        $finish;
    end

endmodule

### sim.f
rtl/ssi_pkg.sv
rtl/ssi_ctrl.sv
rtl/ssi_dpath.sv
rtl/sort_signed_integers_core.sv
verif/ssi_checker.sv
verif/tb_sort_signed_integers_core.sv
